@@ hw/rtl/cascaded_position_velocity_pid_core_defines.svh @@
// assertion macros for the cascaded position/velocity pid core
// used by the checker; expects clk and rst_n in scope
`ifndef CASCADED_POSITION_VELOCITY_PID_CORE_DEFINES_SVH
`define CASCADED_POSITION_VELOCITY_PID_CORE_DEFINES_SVH

// same-cycle implication
`define CPVP_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define CPVP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hw/rtl/cpvp_pkg.sv @@
// shared types and constants for the cascaded position/velocity pid core
// no dependencies
`timescale 1ns / 1ps

package cpvp_pkg;

    localparam int MOTOR_COUNT_DEFAULT = 32;
    localparam int MOTOR_W  = 5;
    localparam int MIDX_W   = 7;
    localparam int GAIN_W   = 32;
    localparam int ERR_W    = 33;
    localparam int INTEG_W  = 48;
    localparam int DATA_W   = 32;
    localparam int SPEED_W  = 31;
    localparam int TORQUE_W = 15;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_OUTER_KP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_KI     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_KD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_KP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_KI     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_KD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LIMIT = 3'd7;

    localparam logic signed [GAIN_W-1:0] OUTER_KP_RESET = 32'sd9830400;
    localparam logic signed [GAIN_W-1:0] INNER_KP_RESET = 32'sd5898;
    localparam logic [SPEED_W-1:0]       SPEED_RESET    = '0;
    localparam logic [TORQUE_W-1:0]      TORQUE_RESET   = 15'd2000;

    typedef struct packed {
        logic [MOTOR_W-1:0]       motor_index;
        logic signed [DATA_W-1:0] position_now;
        logic signed [DATA_W-1:0] velocity_now;
        logic signed [DATA_W-1:0] position_goal;
    } sample_t;

    typedef struct packed {
        logic [MOTOR_W-1:0]         motor_out;
        logic signed [DATA_W-1:0]   position_echo;
        logic signed [DATA_W-1:0]   velocity_command;
        logic signed [TORQUE_W:0]   torque_command;
    } result_t;

endpackage

@@ hw/rtl/cascaded_position_velocity_pid_core.sv @@
// top level of the cascaded position/velocity pid servo core
// depends on cpvp_pkg and cpvp_pid_loop
`timescale 1ns / 1ps

// Per-motor cascaded servo: each sample transaction names a motor and gives
// measured position, measured velocity and target position; the result
// transaction carries the motor index, the echoed target, the velocity
// command (outer loop, clamped to +/- speed_limit) and the torque command
// (inner loop, clamped to +/- torque_limit). Gains are signed Q16.16, each
// loop sum is exact and then truncated toward zero, integrators saturate at
// 48 bits. Throughput is one transaction per clock unless result_ready
// stalls it; a result passes through the two seven-stage loop pipelines in
// series. Each loop updates its per-motor integral and previous error in its
// first stage, so samples for the same motor may follow each other on
// consecutive clocks. Indexes not below MOTOR_COUNT run with zeroed state
// and write nothing. Configuration writes take effect on the next clock and
// are not held back, so issue them only while no transaction is in flight.

module cascaded_position_velocity_pid_core
    import cpvp_pkg::*;
#(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  sample_t               sample,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data
);

    localparam int SIDE_W = 2 * DATA_W;

    // configuration registers
    logic signed [GAIN_W-1:0] outer_kp_reg, outer_ki_reg, outer_kd_reg;
    logic signed [GAIN_W-1:0] inner_kp_reg, inner_ki_reg, inner_kd_reg;
    logic [SPEED_W-1:0]       speed_limit_reg;
    logic [TORQUE_W-1:0]      torque_limit_reg;

    // outer to inner hand-off
    logic                     mid_valid, mid_ready;
    logic [MOTOR_W-1:0]       mid_motor;
    logic signed [SPEED_W:0]  mid_vcmd;
    logic [SIDE_W-1:0]        mid_side;
    logic signed [DATA_W-1:0] mid_vel, mid_goal;

    logic signed [ERR_W-1:0]  outer_err, inner_err;
    logic [MOTOR_W-1:0]       out_motor;
    logic signed [TORQUE_W:0] out_torque;
    logic [SIDE_W-1:0]        out_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_kp_reg     <= OUTER_KP_RESET;
            outer_ki_reg     <= '0;
            outer_kd_reg     <= '0;
            inner_kp_reg     <= INNER_KP_RESET;
            inner_ki_reg     <= '0;
            inner_kd_reg     <= '0;
            speed_limit_reg  <= SPEED_RESET;
            torque_limit_reg <= TORQUE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OUTER_KP:     outer_kp_reg     <= cfg_data;
                REG_OUTER_KI:     outer_ki_reg     <= cfg_data;
                REG_OUTER_KD:     outer_kd_reg     <= cfg_data;
                REG_INNER_KP:     inner_kp_reg     <= cfg_data;
                REG_INNER_KI:     inner_ki_reg     <= cfg_data;
                REG_INNER_KD:     inner_kd_reg     <= cfg_data;
                REG_SPEED_LIMIT:  speed_limit_reg  <= cfg_data[SPEED_W-1:0];
                REG_TORQUE_LIMIT: torque_limit_reg <= cfg_data[TORQUE_W-1:0];
                default:          ;
            endcase
        end
    end

    // position error, 33 bits so it never wraps
    assign outer_err = ERR_W'(sample.position_goal) - ERR_W'(sample.position_now);

    // outer loop: velocity and goal ride along as sideband
    cpvp_pid_loop #(
        .MOTOR_COUNT (MOTOR_COUNT),
        .LIMIT_W     (SPEED_W),
        .SIDE_W      (SIDE_W)
    ) u_outer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_valid),
        .in_ready  (sample_ready),
        .in_motor  (sample.motor_index),
        .in_err    (outer_err),
        .in_side   ({sample.velocity_now, sample.position_goal}),
        .kp        (outer_kp_reg),
        .ki        (outer_ki_reg),
        .kd        (outer_kd_reg),
        .limit     (speed_limit_reg),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_motor (mid_motor),
        .out_cmd   (mid_vcmd),
        .out_side  (mid_side)
    );

    assign mid_vel   = mid_side[SIDE_W-1:DATA_W];
    assign mid_goal  = mid_side[DATA_W-1:0];

    // velocity error against the clamped command
    assign inner_err = ERR_W'(mid_vcmd) - ERR_W'(mid_vel);

    // inner loop: goal and velocity command ride along
    cpvp_pid_loop #(
        .MOTOR_COUNT (MOTOR_COUNT),
        .LIMIT_W     (TORQUE_W),
        .SIDE_W      (SIDE_W)
    ) u_inner (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_motor  (mid_motor),
        .in_err    (inner_err),
        .in_side   ({mid_goal, mid_vcmd}),
        .kp        (inner_kp_reg),
        .ki        (inner_ki_reg),
        .kd        (inner_kd_reg),
        .limit     (torque_limit_reg),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_motor (out_motor),
        .out_cmd   (out_torque),
        .out_side  (out_side)
    );

    // result straight from the inner loop's output register
    always_comb
    begin
        result.motor_out        = out_motor;
        result.position_echo    = out_side[SIDE_W-1:DATA_W];
        result.velocity_command = out_side[DATA_W-1:0];
        result.torque_command   = out_torque;
    end

endmodule

@@ hw/rtl/cpvp_pid_loop.sv @@
// one pid loop as a seven stage elastic pipeline with per-motor state
// depends on cpvp_pkg
`timescale 1ns / 1ps

module cpvp_pid_loop
    import cpvp_pkg::*;
#(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEFAULT,
    parameter int LIMIT_W     = SPEED_W,
    parameter int SIDE_W      = 2 * DATA_W
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [MOTOR_W-1:0]        in_motor,
    input  logic signed [ERR_W-1:0]   in_err,
    input  logic [SIDE_W-1:0]         in_side,
    input  logic signed [GAIN_W-1:0]  kp,
    input  logic signed [GAIN_W-1:0]  ki,
    input  logic signed [GAIN_W-1:0]  kd,
    input  logic [LIMIT_W-1:0]        limit,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [MOTOR_W-1:0]        out_motor,
    output logic signed [LIMIT_W:0]   out_cmd,
    output logic [SIDE_W-1:0]         out_side
);

    localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int SUM_W = 81;

    // per-motor state
    logic signed [INTEG_W-1:0] integ_reg [MOTOR_COUNT];
    logic signed [ERR_W-1:0]   prev_reg  [MOTOR_COUNT];

    logic en1, en2, en3, en4, en5, en6, en7;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg;

    // stage 1: sample
    logic [MOTOR_W-1:0]        s1_motor_reg;
    logic signed [ERR_W-1:0]   s1_err_reg;
    logic [SIDE_W-1:0]         s1_side_reg;
    logic                      s1_hit_reg;
    // stage 2: error terms
    logic [MOTOR_W-1:0]        s2_motor_reg;
    logic [SIDE_W-1:0]         s2_side_reg;
    logic signed [ERR_W-1:0]   s2_e_reg;
    logic signed [INTEG_W-1:0] s2_i_reg;
    logic signed [ERR_W:0]     s2_d_reg;
    // stage 3: products
    logic [MOTOR_W-1:0]        s3_motor_reg;
    logic [SIDE_W-1:0]         s3_side_reg;
    logic signed [64:0]        s3_pe_reg;
    logic signed [56:0]        s3_ilo_reg;
    logic signed [55:0]        s3_ihi_reg;
    logic signed [65:0]        s3_pd_reg;
    // stage 4: partial sums
    logic [MOTOR_W-1:0]        s4_motor_reg;
    logic [SIDE_W-1:0]         s4_side_reg;
    logic signed [SUM_W-1:0]   s4_sa_reg;
    logic signed [SUM_W-1:0]   s4_sb_reg;
    // stage 5: full sum
    logic [MOTOR_W-1:0]        s5_motor_reg;
    logic [SIDE_W-1:0]         s5_side_reg;
    logic signed [SUM_W-1:0]   s5_sum_reg;
    // stage 6: truncated magnitude
    logic [MOTOR_W-1:0]        s6_motor_reg;
    logic [SIDE_W-1:0]         s6_side_reg;
    logic                      s6_neg_reg;
    logic [SUM_W-17:0]         s6_mag_reg;
    // stage 7: clamped command
    logic [MOTOR_W-1:0]        s7_motor_reg;
    logic [SIDE_W-1:0]         s7_side_reg;
    logic signed [LIMIT_W:0]   s7_cmd_reg;

    logic                      in_hit;
    logic [MIDX_W-1:0]         s1_mext;
    logic [IDX_W-1:0]          s1_idx;
    logic signed [INTEG_W-1:0] integ_old;
    logic signed [ERR_W-1:0]   prev_old;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W-1:0] integ_new;
    logic signed [ERR_W:0]     d_new;
    logic signed [64:0]        pe;
    logic signed [56:0]        ilo;
    logic signed [55:0]        ihi;
    logic signed [65:0]        pd;
    logic signed [SUM_W-1:0]   sa;
    logic signed [SUM_W-1:0]   sb;
    logic [SUM_W-1:0]          mag;
    logic                      over;
    logic [LIMIT_W-1:0]        res;
    logic signed [LIMIT_W:0]   res_ext;
    logic signed [LIMIT_W:0]   cmd;

    assign en7 = !s7_valid_reg || out_ready;
    assign en6 = !s6_valid_reg || en7;
    assign en5 = !s5_valid_reg || en6;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign in_ready = en1;

    assign in_hit = MIDX_W'(in_motor) < MIDX_W'(MOTOR_COUNT);

    // read-modify-write of the motor state in stage 1
    always_comb
    begin
        s1_mext   = MIDX_W'(s1_motor_reg);
        s1_idx    = s1_mext[IDX_W-1:0];
        integ_old = s1_hit_reg ? integ_reg[s1_idx] : '0;
        prev_old  = s1_hit_reg ? prev_reg[s1_idx] : '0;
        integ_sum = (INTEG_W+1)'(integ_old) + (INTEG_W+1)'(s1_err_reg);
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1])
        begin
            integ_new = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                           : {1'b0, {(INTEG_W-1){1'b1}}};
        end
        else
        begin
            integ_new = integ_sum[INTEG_W-1:0];
        end
        d_new = (ERR_W+1)'(s1_err_reg) - (ERR_W+1)'(prev_old);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MOTOR_COUNT; k++)
            begin
                integ_reg[k] <= '0;
                prev_reg[k]  <= '0;
            end
        end
        else if (s1_valid_reg && en2 && s1_hit_reg)
        begin
            integ_reg[s1_idx] <= integ_new;
            prev_reg[s1_idx]  <= s1_err_reg;
        end
    end

    // ki * integral is split into two 24-bit halves
    always_comb
    begin
        pe  = kp * s2_e_reg;
        ilo = ki * $signed({1'b0, s2_i_reg[23:0]});
        ihi = ki * $signed(s2_i_reg[INTEG_W-1:24]);
        pd  = kd * s2_d_reg;
        sa  = SUM_W'(s3_pe_reg) + SUM_W'(s3_pd_reg);
        sb  = (SUM_W'(s3_ihi_reg) <<< 24) + SUM_W'(s3_ilo_reg);
        mag = s5_sum_reg[SUM_W-1] ? SUM_W'(-s5_sum_reg) : SUM_W'(s5_sum_reg);
        over = s6_mag_reg > (SUM_W-16)'(limit);
        res  = over ? limit : s6_mag_reg[LIMIT_W-1:0];
        res_ext = $signed({1'b0, res});
        cmd  = s6_neg_reg ? -res_ext : res_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= in_valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
            if (en5) s5_valid_reg <= s4_valid_reg;
            if (en6) s6_valid_reg <= s5_valid_reg;
            if (en7) s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_motor_reg <= in_motor;
            s1_err_reg   <= in_err;
            s1_side_reg  <= in_side;
            s1_hit_reg   <= in_hit;
        end
        if (en2)
        begin
            s2_motor_reg <= s1_motor_reg;
            s2_side_reg  <= s1_side_reg;
            s2_e_reg     <= s1_err_reg;
            s2_i_reg     <= integ_new;
            s2_d_reg     <= d_new;
        end
        if (en3)
        begin
            s3_motor_reg <= s2_motor_reg;
            s3_side_reg  <= s2_side_reg;
            s3_pe_reg    <= pe;
            s3_ilo_reg   <= ilo;
            s3_ihi_reg   <= ihi;
            s3_pd_reg    <= pd;
        end
        if (en4)
        begin
            s4_motor_reg <= s3_motor_reg;
            s4_side_reg  <= s3_side_reg;
            s4_sa_reg    <= sa;
            s4_sb_reg    <= sb;
        end
        if (en5)
        begin
            s5_motor_reg <= s4_motor_reg;
            s5_side_reg  <= s4_side_reg;
            s5_sum_reg   <= s4_sa_reg + s4_sb_reg;
        end
        if (en6)
        begin
            s6_motor_reg <= s5_motor_reg;
            s6_side_reg  <= s5_side_reg;
            s6_neg_reg   <= s5_sum_reg[SUM_W-1];
            s6_mag_reg   <= mag[SUM_W-1:16];
        end
        if (en7)
        begin
            s7_motor_reg <= s6_motor_reg;
            s7_side_reg  <= s6_side_reg;
            s7_cmd_reg   <= cmd;
        end
    end

    assign out_valid = s7_valid_reg;
    assign out_motor = s7_motor_reg;
    assign out_cmd   = s7_cmd_reg;
    assign out_side  = s7_side_reg;

endmodule

@@ hw/rtl/cpvp_checker.sv @@
// port-level checker for the cascaded position/velocity pid core, with bind
// depends on cpvp_pkg and cascaded_position_velocity_pid_core_defines.svh
`timescale 1ns / 1ps
`include "cascaded_position_velocity_pid_core_defines.svh"

module cpvp_checker
    import cpvp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    input  logic                  sample_ready,
    input  sample_t               sample,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data
);

    logic [SPEED_W-1:0]      speed_lim_reg;
    logic [TORQUE_W-1:0]     torque_lim_reg;
    logic signed [DATA_W:0]  vc, vl;
    logic signed [TORQUE_W+1:0] tc, tl;
    logic                    vc_ok, tc_ok;

    // shadow copies of the limits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_lim_reg  <= SPEED_RESET;
            torque_lim_reg <= TORQUE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_SPEED_LIMIT)
            begin
                speed_lim_reg <= cfg_data[SPEED_W-1:0];
            end
            if (cfg_index == REG_TORQUE_LIMIT)
            begin
                torque_lim_reg <= cfg_data[TORQUE_W-1:0];
            end
        end
    end

    always_comb
    begin
        vc = (DATA_W+1)'(result.velocity_command);
        vl = $signed({2'b00, speed_lim_reg});
        tc = (TORQUE_W+2)'(result.torque_command);
        tl = $signed({2'b00, torque_lim_reg});
        vc_ok = (vc <= vl) && (vc >= -vl);
        tc_ok = (tc <= tl) && (tc >= -tl);
    end

    `CPVP_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")
    `CPVP_ASSERT_NEXT(a_sample_hold, sample_valid && !sample_ready, $stable(sample), "sample changed while stalled")
    `CPVP_ASSERT_NOW(a_speed_clamp, result_valid, vc_ok, "velocity command beyond speed limit")
    `CPVP_ASSERT_NOW(a_torque_clamp, result_valid, tc_ok, "torque command beyond torque limit")
    `CPVP_ASSERT_NOW(a_ready_empty, !result_valid, sample_ready, "sample refused with empty output")

endmodule

bind cascaded_position_velocity_pid_core cpvp_checker u_cpvp_checker (.*);

@@ test/tb_top.sv @@
// self-checking testbench for cascaded_position_velocity_pid_core
// depends on cpvp_pkg and the core rtl; a scoreboard class predicts each result
`timescale 1ns / 1ps

module tb_top;
    import cpvp_pkg::*;

    // per-motor servo predictor and store of expected result transactions
    class servo_scoreboard;
        longint okp, oki, okd, ikp, iki, ikd;
        longint speed_lim, torque_lim;
        longint pos_integ[32];
        longint pos_prev[32];
        longint vel_integ[32];
        longint vel_prev[32];
        result_t expected_q[$];
        int errors;

        function new();
            okp = 9830400; oki = 0; okd = 0;
            ikp = 5898; iki = 0; ikd = 0;
            speed_lim = 0;
            torque_lim = 2000;
            errors = 0;
            foreach (pos_integ[k])
            begin
                pos_integ[k] = 0;
                pos_prev[k] = 0;
                vel_integ[k] = 0;
                vel_prev[k] = 0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
            case (idx)
                REG_OUTER_KP:     okp = longint'($signed(d));
                REG_OUTER_KI:     oki = longint'($signed(d));
                REG_OUTER_KD:     okd = longint'($signed(d));
                REG_INNER_KP:     ikp = longint'($signed(d));
                REG_INNER_KI:     iki = longint'($signed(d));
                REG_INNER_KD:     ikd = longint'($signed(d));
                REG_SPEED_LIMIT:  speed_lim = longint'(d[SPEED_W-1:0]);
                REG_TORQUE_LIMIT: torque_lim = longint'(d[TORQUE_W-1:0]);
                default: ;
            endcase
        endfunction

        // one pid loop: exact sum, truncation toward zero, symmetric clamp
        function longint pid_loop(longint err, ref longint integ, ref longint prev,
                                  input longint kp, longint ki, longint kd,
                                  longint limit);
            logic signed [95:0] wkp, wki, wkd, werr, wi, wd, acc, mag;
            longint dif, isum;
            dif = err - prev;
            isum = integ + err;
            if (isum > 64'sh7FFF_FFFF_FFFF)
                isum = 64'sh7FFF_FFFF_FFFF;
            else if (isum < -64'sh8000_0000_0000)
                isum = -64'sh8000_0000_0000;
            integ = isum;
            prev = err;
            wkp = kp; wki = ki; wkd = kd;
            werr = err; wi = isum; wd = dif;
            acc = wkp * werr + wki * wi + wkd * wd;
            mag = (acc < 0) ? -acc : acc;
            mag = mag >> 16;
            if (mag > limit)
                mag = limit;
            return (acc < 0) ? -longint'(mag) : longint'(mag);
        endfunction

        function void note_sample(sample_t s);
            result_t r;
            longint pi, pp, vi, vp, vcmd, tcmd;
            int m;
            m = s.motor_index;
            pi = pos_integ[m]; pp = pos_prev[m];
            vi = vel_integ[m]; vp = vel_prev[m];
            vcmd = pid_loop(longint'(s.position_goal) - longint'(s.position_now),
                            pi, pp, okp, oki, okd, speed_lim);
            tcmd = pid_loop(vcmd - longint'(s.velocity_now), vi, vp,
                            ikp, iki, ikd, torque_lim);
            pos_integ[m] = pi; pos_prev[m] = pp;
            vel_integ[m] = vi; vel_prev[m] = vp;
            r.motor_out = s.motor_index;
            r.position_echo = s.position_goal;
            r.velocity_command = vcmd[31:0];
            r.torque_command = tcmd[15:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(result_t r);
            result_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: %p", $realtime, r);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (r.motor_out !== e.motor_out)
            begin
                $display("%0t: motor_out exp %0d act %0d", $realtime,
                         e.motor_out, r.motor_out);
                errors++;
            end
            if (r.position_echo !== e.position_echo)
            begin
                $display("%0t: position_echo exp %0d act %0d", $realtime,
                         e.position_echo, r.position_echo);
                errors++;
            end
            if (r.velocity_command !== e.velocity_command)
            begin
                $display("%0t: velocity_command exp %0d act %0d", $realtime,
                         e.velocity_command, r.velocity_command);
                errors++;
            end
            if (r.torque_command !== e.torque_command)
            begin
                $display("%0t: torque_command exp %0d act %0d", $realtime,
                         e.torque_command, r.torque_command);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 sample_valid;
    logic                 sample_ready;
    sample_t              sample;
    logic                 result_valid;
    logic                 result_ready;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    servo_scoreboard sb;

    // sender and receiver behaviour knobs
    bit no_gaps;         // sender streams back to back
    int recv_mode;       // 0 always ready, 1 mostly ready, 2 mostly stalled
    int hold_cycles;     // long receiver hold-off, counted down by the receiver
    int burst_left;

    cascaded_position_velocity_pid_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // monitor: sample both channels on the edge, before any update lands
    always @(posedge clk)
    begin
        if (rst_n && sample_valid && sample_ready)
            sb.note_sample(sample);
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    // receiver: stall pattern of its own, plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            result_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (recv_mode == 0)
            result_ready <= 1'b1;
        else if (recv_mode == 1)
            result_ready <= ($urandom_range(0, 3) != 0);
        else
            result_ready <= ($urandom_range(0, 3) == 0);
    end

    // drive one sample transaction and wait until it is taken
    task automatic send_sample(sample_t s);
        int gap;
        if (!no_gaps)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 24);
                if (gap > 0)
                begin
                    sample_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
    endtask

    // register write, only issued while the core is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        sb.set_reg(idx, d);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for every expected result, then for the pipeline latency
    task automatic drain();
        sample_valid <= 1'b0;
        // let the monitor note the last accepted sample first
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return $urandom();
        else if (pick < 50)
            return 32'($signed($urandom_range(0, 2000)) - 1000);
        else if (pick < 65)
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0;
                default: return 32'hFFFF_FFFF;
            endcase
        else
            return 32'($signed($urandom_range(0, 2097152)) - 1048576);
    endfunction

    function automatic logic [31:0] rand_gain();
        if ($urandom_range(0, 4) == 0)
            return $urandom();
        return 32'($signed($urandom_range(0, 262144)) - 131072);
    endfunction

    function automatic sample_t make_sample(int m, logic [31:0] pos,
                                            logic [31:0] vel, logic [31:0] goal);
        sample_t s;
        s.motor_index = m[MOTOR_W-1:0];
        s.position_now = pos;
        s.velocity_now = vel;
        s.position_goal = goal;
        return s;
    endfunction

    // random phase: most samples go to a few motors so state builds up
    task automatic random_phase(int count);
        int m;
        logic [31:0] goal, pos;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 3) == 0)
                m = $urandom_range(0, 31);
            else
                m = $urandom_range(0, 3);
            goal = rand_word();
            pos = ($urandom_range(0, 2) == 0) ? rand_word()
                                              : goal + $urandom_range(0, 512) - 256;
            send_sample(make_sample(m, pos, rand_word(), goal));
        end
    endtask

    initial
    begin
        #20ms;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        result_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_gaps = 1'b0;
        recv_mode = 1;
        hold_cycles = 0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset settings: speed limit zero forces velocity command to zero
        send_sample(make_sample(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_sample(make_sample(31, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        send_sample(make_sample(7, 0, 0, 0));
        send_sample(make_sample(7, 0, 32'hFFFF_FFFF, 0));
        drain();

        // open both limits fully, all gains nonzero
        write_reg(REG_SPEED_LIMIT, 32'h7FFF_FFFF);
        write_reg(REG_TORQUE_LIMIT, 32'h0000_7FFF);
        write_reg(REG_OUTER_KP, 32'h0001_0000);
        write_reg(REG_OUTER_KI, 32'h0000_4000);
        write_reg(REG_OUTER_KD, 32'h0000_8000);
        write_reg(REG_INNER_KP, 32'h0000_2000);
        write_reg(REG_INNER_KI, 32'h0000_0100);
        write_reg(REG_INNER_KD, 32'hFFFF_F000);
        // first sample per motor: derivative equals the error
        send_sample(make_sample(1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        send_sample(make_sample(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        // same motor in a row exercises the per-motor state read-modify-write
        send_sample(make_sample(3, 100, 5, 200));
        send_sample(make_sample(3, 120, -5, 200));
        send_sample(make_sample(3, 180, 50, 200));
        send_sample(make_sample(3, 200, 0, 200));
        send_sample(make_sample(31, -1000, 300, 1000));
        send_sample(make_sample(0, 1000, -300, -1000));
        drain();

        // extreme gains, tiny limits
        write_reg(REG_OUTER_KP, 32'h8000_0000);
        write_reg(REG_OUTER_KI, 32'h7FFF_FFFF);
        write_reg(REG_OUTER_KD, 32'h8000_0000);
        write_reg(REG_INNER_KP, 32'h7FFF_FFFF);
        write_reg(REG_INNER_KI, 32'h8000_0000);
        write_reg(REG_INNER_KD, 32'h7FFF_FFFF);
        write_reg(REG_SPEED_LIMIT, 32'h0000_0001);
        write_reg(REG_TORQUE_LIMIT, 32'h0000_0000);
        send_sample(make_sample(4, 5, 0, -5));
        send_sample(make_sample(4, -5, 1, 5));
        send_sample(make_sample(4, 0, -1, 0));
        drain();

        // integral build-up: hold the largest error on two motors so the
        // integrals grow large, streaming at full rate
        write_reg(REG_OUTER_KP, 32'h0);
        write_reg(REG_OUTER_KI, 32'h0000_0001);
        write_reg(REG_OUTER_KD, 32'h0);
        write_reg(REG_INNER_KP, 32'h0);
        write_reg(REG_INNER_KI, 32'h0000_0001);
        write_reg(REG_INNER_KD, 32'h0);
        write_reg(REG_SPEED_LIMIT, 32'h7FFF_FFFF);
        write_reg(REG_TORQUE_LIMIT, 32'h0000_7FFF);
        no_gaps = 1'b1;
        recv_mode = 0;
        for (int n = 0; n < 100; n++)
        begin
            send_sample(make_sample(9, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
            send_sample(make_sample(10, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        end
        drain();
        no_gaps = 1'b0;

        // random phases, each with its own settings
        for (int ph = 0; ph < 5; ph++)
        begin
            write_reg(REG_OUTER_KP, rand_gain());
            write_reg(REG_OUTER_KI, rand_gain());
            write_reg(REG_OUTER_KD, rand_gain());
            write_reg(REG_INNER_KP, rand_gain());
            write_reg(REG_INNER_KI, rand_gain());
            write_reg(REG_INNER_KD, rand_gain());
            write_reg(REG_SPEED_LIMIT, (ph == 0) ? 32'h7FFF_FFFF : $urandom_range(0, 1 << 22));
            write_reg(REG_TORQUE_LIMIT, (ph == 1) ? 32'h0 : $urandom_range(0, 32767));
            recv_mode = ph % 3;
            // long receiver hold-off while the sender keeps offering, so the core backs up
            if (ph == 1)
                hold_cycles = 300;
            random_phase(112);
            drain();
        end

        if (sb.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/cpvp_pkg.sv
hw/rtl/cpvp_pid_loop.sv
hw/rtl/cascaded_position_velocity_pid_core.sv
hw/rtl/cpvp_checker.sv
test/tb_top.sv
